/* rtl/lfu_pkg.sv */
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants
// Sizes, handshake payloads and cell control structs for the lfu cache table.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int DATA_BITS  = 32;
    localparam int COUNT_BITS = 16;
    localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_BITS   = $clog2(ENTRIES + 1);
    localparam int CAP_BITS   = 5;

    localparam logic [CAP_BITS-1:0]   CAP_RESET = CAP_BITS'(16);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic                        cmd;
        logic [KEY_BITS-1:0]         key;
        logic signed [DATA_BITS-1:0] write_value;
    } in_t;

    typedef struct packed {
        logic                        hit;
        logic signed [DATA_BITS-1:0] read_value;
        logic                        evicted;
        logic [KEY_BITS-1:0]         evicted_key;
    } out_t;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_TOUCH,
        OP_INSERT
    } cell_op_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        cell_op_t             op;
        logic [IDX_BITS-1:0]  target;
        logic [IDX_BITS-1:0]  ref_rank;
        logic                 age_all;
        logic                 write_data;
        logic [KEY_BITS-1:0]  key;
        logic [DATA_BITS-1:0] data;
    } cell_cmd_t;

    typedef struct packed {
        logic                 valid;
        logic                 match;
        logic [IDX_BITS-1:0]  rank;
        logic [DATA_BITS-1:0] data;
    } cell_stat_t;

    // running eviction candidate handed from cell to cell
    typedef struct packed {
        logic                  found;
        logic [COUNT_BITS-1:0] count;
        logic [IDX_BITS-1:0]   rank;
        logic [IDX_BITS-1:0]   idx;
        logic [KEY_BITS-1:0]   key;
    } cand_t;

endpackage

`default_nettype wire

/* rtl/lfu_cache_table.sv */
// ----------------------------------------------------------------------------
// lfu_cache_table: key-value cache with lfu replacement and lru tie break
// Row of entry cells under a small controller.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry a get or put transaction (in_data), out_valid/
//   out_ready carry one result transaction (out_data) per input.
//   cfg_write_en/cfg_write_data set the capacity limit; write only when idle.
// Timing:
//   a hit, a get miss or a put miss with free room passes the lookup state
//   and then the send state. A put miss at full capacity scans the cell row
//   for the victim: the candidate travels one cell per cycle. One transaction
//   is in work at a time; in_ready is high only in the idle state.
// Reset:
//   all entries invalid, occupancy 0, capacity limit 16.
// Stall:
//   a finished result waits in the output register while out_ready is low;
//   the next transaction is taken as soon as the controller is back in idle.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cache_table (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_ready,
    input  wire  lfu_pkg::in_t                in_data,
    output logic                              out_valid,
    input  wire                               out_ready,
    output lfu_pkg::out_t                     out_data,
    input  wire                               cfg_write_en,
    input  wire  [lfu_pkg::CAP_BITS-1:0]      cfg_write_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOOK = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_SEND = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    lfu_pkg::in_t                    req_reg, req_next;
    lfu_pkg::out_t                   res_reg, res_next;
    lfu_pkg::out_t                   out_data_reg, out_data_next;
    logic                            out_valid_reg, out_valid_next;
    logic [lfu_pkg::CAP_BITS-1:0]    cap_reg, cap_next;
    logic [lfu_pkg::OCC_BITS-1:0]    occ_reg, occ_next;
    logic [lfu_pkg::OCC_BITS-1:0]    scan_cnt_reg, scan_cnt_next;

    lfu_pkg::cell_cmd_t              cell_cmd;
    lfu_pkg::cell_stat_t             stat [lfu_pkg::ENTRIES];
    lfu_pkg::cand_t                  cand [lfu_pkg::ENTRIES+1];

    logic                            hit;
    logic [lfu_pkg::IDX_BITS-1:0]    found_idx;
    logic [lfu_pkg::IDX_BITS-1:0]    found_rank;
    logic [lfu_pkg::DATA_BITS-1:0]   found_data;
    logic [lfu_pkg::IDX_BITS-1:0]    free_idx;
    logic [lfu_pkg::OCC_BITS-1:0]    cap_eff;
    lfu_pkg::cand_t                  victim;

    assign cand[0] = '0;

    for (genvar g = 0; g < lfu_pkg::ENTRIES; g++)
    begin : g_cell
        lfu_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (lfu_pkg::IDX_BITS'(g)),
            .look_key (req_reg.key),
            .cmd      (cell_cmd),
            .cand_in  (cand[g]),
            .cand_out (cand[g+1]),
            .stat     (stat[g])
        );
    end

    assign victim = cand[lfu_pkg::ENTRIES];

    // first matching entry and first free entry
    always_comb
    begin
        hit        = 1'b0;
        found_idx  = '0;
        found_rank = '0;
        found_data = '0;
        free_idx   = '0;
        for (int i = lfu_pkg::ENTRIES - 1; i >= 0; i--)
        begin
            if (stat[i].match)
            begin
                hit        = 1'b1;
                found_idx  = lfu_pkg::IDX_BITS'(i);
                found_rank = stat[i].rank;
                found_data = stat[i].data;
            end
            if (!stat[i].valid)
                free_idx = lfu_pkg::IDX_BITS'(i);
        end
    end

    assign cap_eff = (cap_reg > lfu_pkg::CAP_BITS'(lfu_pkg::ENTRIES)) ?
                     lfu_pkg::OCC_BITS'(lfu_pkg::ENTRIES) : lfu_pkg::OCC_BITS'(cap_reg);

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        occ_next       = occ_reg;
        scan_cnt_next  = scan_cnt_reg;
        cap_next       = cfg_write_en ? cfg_write_data : cap_reg;

        cell_cmd            = '0;
        cell_cmd.op         = lfu_pkg::OP_NOP;
        cell_cmd.key        = req_reg.key;
        cell_cmd.data       = req_reg.write_value;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_data;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                res_next   = '0;
                state_next = ST_SEND;
                if (hit)
                begin
                    cell_cmd.op         = lfu_pkg::OP_TOUCH;
                    cell_cmd.target     = found_idx;
                    cell_cmd.ref_rank   = found_rank;
                    cell_cmd.write_data = (req_reg.cmd == lfu_pkg::CMD_PUT);
                    res_next.hit        = 1'b1;
                    if (req_reg.cmd == lfu_pkg::CMD_GET)
                        res_next.read_value = found_data;
                end
                else if (req_reg.cmd == lfu_pkg::CMD_PUT && cap_eff != '0)
                begin
                    if (occ_reg >= cap_eff)
                    begin
                        scan_cnt_next = '0;
                        state_next    = ST_SCAN;
                    end
                    else
                    begin
                        cell_cmd.op      = lfu_pkg::OP_INSERT;
                        cell_cmd.target  = free_idx;
                        cell_cmd.age_all = 1'b1;
                        occ_next         = occ_reg + lfu_pkg::OCC_BITS'(1);
                    end
                end
            end
            ST_SCAN:
            begin
                // the candidate is registered in every cell on its way to the row end
                if (scan_cnt_reg == lfu_pkg::OCC_BITS'(lfu_pkg::ENTRIES))
                begin
                    cell_cmd.op          = lfu_pkg::OP_INSERT;
                    cell_cmd.target      = victim.idx;
                    cell_cmd.ref_rank    = victim.rank;
                    res_next             = '0;
                    res_next.evicted     = 1'b1;
                    res_next.evicted_key = victim.key;
                    state_next           = ST_SEND;
                end
                else
                    scan_cnt_next = scan_cnt_reg + lfu_pkg::OCC_BITS'(1);
            end
            ST_SEND:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cap_reg       <= lfu_pkg::CAP_RESET;
            occ_reg       <= '0;
            scan_cnt_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cap_reg       <= cap_next;
            occ_reg       <= occ_next;
            scan_cnt_reg  <= scan_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

/* rtl/lfu_cell.sv */
// ----------------------------------------------------------------------------
// lfu_cell: one entry of the lfu cache table
// Holds key, data, use count and recency rank; compares the lookup key and
// passes the best eviction candidate so far on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cell (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire  [lfu_pkg::IDX_BITS-1:0]     cell_idx,
    input  wire  [lfu_pkg::KEY_BITS-1:0]     look_key,
    input  wire  lfu_pkg::cell_cmd_t         cmd,
    input  wire  lfu_pkg::cand_t             cand_in,
    output lfu_pkg::cand_t                   cand_out,
    output lfu_pkg::cell_stat_t              stat
);

    logic                             valid_reg, valid_next;
    logic [lfu_pkg::KEY_BITS-1:0]     key_reg, key_next;
    logic [lfu_pkg::DATA_BITS-1:0]    data_reg, data_next;
    logic [lfu_pkg::COUNT_BITS-1:0]   count_reg, count_next;
    logic [lfu_pkg::IDX_BITS-1:0]     rank_reg, rank_next;
    lfu_pkg::cand_t                   cand_reg, cand_next;
    logic                             is_target;
    logic                             take_me;

    assign is_target = (cmd.target == cell_idx);

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        data_next  = data_reg;
        count_next = count_reg;
        rank_next  = rank_reg;
        case (cmd.op)
            lfu_pkg::OP_TOUCH:
            begin
                if (is_target)
                begin
                    rank_next = '0;
                    if (count_reg != lfu_pkg::COUNT_MAX)
                        count_next = count_reg + lfu_pkg::COUNT_BITS'(1);
                    if (cmd.write_data)
                        data_next = cmd.data;
                end
                else if (valid_reg && rank_reg < cmd.ref_rank)
                    rank_next = rank_reg + lfu_pkg::IDX_BITS'(1);
            end
            lfu_pkg::OP_INSERT:
            begin
                if (is_target)
                begin
                    valid_next = 1'b1;
                    key_next   = cmd.key;
                    data_next  = cmd.data;
                    count_next = lfu_pkg::COUNT_BITS'(1);
                    rank_next  = '0;
                end
                else if (valid_reg && (cmd.age_all || rank_reg < cmd.ref_rank))
                    rank_next = rank_reg + lfu_pkg::IDX_BITS'(1);
            end
            default:
            begin
            end
        endcase
    end

    // lowest count wins, older entry on equal count
    assign take_me = valid_reg &&
                     (!cand_in.found || count_reg < cand_in.count ||
                      (count_reg == cand_in.count && rank_reg > cand_in.rank));

    always_comb
    begin
        cand_next = cand_in;
        if (take_me)
        begin
            cand_next.found = 1'b1;
            cand_next.count = count_reg;
            cand_next.rank  = rank_reg;
            cand_next.idx   = cell_idx;
            cand_next.key   = key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cand_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cand_reg  <= cand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        data_reg  <= data_next;
        count_reg <= count_next;
        rank_reg  <= rank_next;
    end

    assign cand_out   = cand_reg;
    assign stat.valid = valid_reg;
    assign stat.match = valid_reg && (key_reg == look_key);
    assign stat.rank  = rank_reg;
    assign stat.data  = data_reg;

endmodule

`default_nettype wire

/* verif/lfu_cache_table_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lfu_cache_table_tb: self-checking bench for the lfu cache table
// Drives get/put transactions with random gaps, mirrors the cache in a local
// model and compares every result field against it across capacity settings.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cache_table_tb;

    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    lfu_pkg::in_t in_data;
    logic out_valid;
    logic out_ready;
    lfu_pkg::out_t out_data;
    logic cfg_write_en;
    logic [lfu_pkg::CAP_BITS-1:0] cfg_write_data;

    lfu_cache_table uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_write_en(cfg_write_en),
        .cfg_write_data(cfg_write_data)
    );

    // local copy of the cache
    logic                           mdl_valid [lfu_pkg::ENTRIES];
    logic [lfu_pkg::KEY_BITS-1:0]   mdl_key   [lfu_pkg::ENTRIES];
    logic [lfu_pkg::DATA_BITS-1:0]  mdl_data  [lfu_pkg::ENTRIES];
    logic [lfu_pkg::COUNT_BITS-1:0] mdl_count [lfu_pkg::ENTRIES];
    int                             mdl_rank  [lfu_pkg::ENTRIES];
    int                             mdl_occ;
    int                             mdl_cap;

    lfu_pkg::in_t  pending_txn [$];
    lfu_pkg::out_t expected_res [$];
    int   sent_count;
    int   issued_count;
    int   recv_count;
    int   ack_count;
    int   mismatch_count;
    int   cycle_count;
    int   in_gap;
    int   out_gap;

    // moves entry s to most recent and bumps its count
    function automatic void touch_entry(int s);
        int r;
        r = mdl_rank[s];
        for (int i = 0; i < lfu_pkg::ENTRIES; i++)
            if (mdl_valid[i] && mdl_rank[i] < r)
                mdl_rank[i]++;
        mdl_rank[s] = 0;
        if (mdl_count[s] != lfu_pkg::COUNT_MAX)
            mdl_count[s]++;
    endfunction

    function automatic lfu_pkg::out_t cache_access(lfu_pkg::in_t t);
        lfu_pkg::out_t r;
        int found;
        int cap;
        int slot;
        int v;
        int vr;
        r = '0;
        found = -1;
        cap = (mdl_cap > lfu_pkg::ENTRIES) ? lfu_pkg::ENTRIES : mdl_cap;
        for (int i = 0; i < lfu_pkg::ENTRIES; i++)
            if (found < 0 && mdl_valid[i] && mdl_key[i] == t.key)
                found = i;
        if (found >= 0) begin
            r.hit = 1'b1;
            if (t.cmd == lfu_pkg::CMD_PUT)
                mdl_data[found] = t.write_value;
            else
                r.read_value = mdl_data[found];
            touch_entry(found);
            return r;
        end
        if (t.cmd == lfu_pkg::CMD_GET || cap == 0)
            return r;
        slot = -1;
        if (mdl_occ >= cap) begin
            v = -1;
            for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
                if (!mdl_valid[i])
                    continue;
                if (v < 0 || mdl_count[i] < mdl_count[v] ||
                    (mdl_count[i] == mdl_count[v] && mdl_rank[i] > mdl_rank[v]))
                    v = i;
            end
            if (v >= 0) begin
                vr = mdl_rank[v];
                r.evicted = 1'b1;
                r.evicted_key = mdl_key[v];
                mdl_valid[v] = 1'b0;
                for (int i = 0; i < lfu_pkg::ENTRIES; i++)
                    if (mdl_valid[i] && mdl_rank[i] > vr)
                        mdl_rank[i]--;
                if (mdl_occ > 0)
                    mdl_occ--;
                slot = v;
            end
        end
        if (slot < 0)
            for (int i = 0; i < lfu_pkg::ENTRIES; i++)
                if (slot < 0 && !mdl_valid[i])
                    slot = i;
        if (slot < 0)
            return r;
        for (int i = 0; i < lfu_pkg::ENTRIES; i++)
            if (mdl_valid[i])
                mdl_rank[i]++;
        mdl_valid[slot] = 1'b1;
        mdl_key[slot] = t.key;
        mdl_data[slot] = t.write_value;
        mdl_count[slot] = lfu_pkg::COUNT_BITS'(1);
        mdl_rank[slot] = 0;
        mdl_occ++;
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver: one transaction at a time, random gap before each
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            in_data      <= '0;
            issued_count <= 0;
            in_gap       <= $urandom_range(0, 5);
        end
        else if (in_valid && sent_count == issued_count)
        begin
            // accepted at the last rising edge
            in_valid <= 1'b0;
            in_gap   <= $urandom_range(0, 5);
        end
        else if (!in_valid)
        begin
            if (in_gap > 0)
                in_gap <= in_gap - 1;
            else if (pending_txn.size() > 0)
            begin
                in_data      <= pending_txn[0];
                in_valid     <= 1'b1;
                issued_count <= issued_count + 1;
            end
        end
    end

    // acceptance seen at the rising edge feeds the model
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            expected_res.push_back(cache_access(in_data));
            void'(pending_txn.pop_front());
            sent_count <= sent_count + 1;
        end
    end

    // receiver stalls, a fresh wait drawn for every result
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ack_count <= 0;
            out_gap   <= $urandom_range(0, 5);
        end
        else if (out_ready && recv_count != ack_count)
        begin
            out_ready <= 1'b0;
            ack_count <= recv_count;
            out_gap   <= $urandom_range(0, 5);
        end
        else if (out_gap > 0)
        begin
            out_ready <= 1'b0;
            if (out_valid)
                out_gap <= out_gap - 1;
        end
        else
            out_ready <= 1'b1;
    end

    // monitor
    always @(posedge clk)
    begin
        lfu_pkg::out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            recv_count <= recv_count + 1;
            if (expected_res.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transaction %p", out_data);
            end
            else
            begin
                want = expected_res.pop_front();
                if (out_data.hit !== want.hit || out_data.read_value !== want.read_value ||
                    out_data.evicted !== want.evicted ||
                    out_data.evicted_key !== want.evicted_key)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: expected hit=%0b rd=%0d ev=%0b evk=%h,",
                                  " got hit=%0b rd=%0d ev=%0b evk=%h"},
                            want.hit, want.read_value, want.evicted, want.evicted_key,
                            out_data.hit, out_data.read_value, out_data.evicted,
                            out_data.evicted_key);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic lfu_pkg::in_t make_txn(logic c, logic [lfu_pkg::KEY_BITS-1:0] k,
                                              logic [lfu_pkg::DATA_BITS-1:0] v);
        lfu_pkg::in_t t;
        t.cmd = c;
        t.key = k;
        t.write_value = v;
        return t;
    endfunction

    // draws a key from a small pool so hits and evictions are frequent
    function automatic logic [lfu_pkg::KEY_BITS-1:0] pick_key(int pool);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return $urandom;
        else if (r == 1)
            return ~lfu_pkg::KEY_BITS'($urandom_range(0, pool));
        return lfu_pkg::KEY_BITS'($urandom_range(0, pool));
    endfunction

    task automatic drain();
        int target;
        target = sent_count + pending_txn.size();
        while (sent_count < target || expected_res.size() > 0)
            @(posedge clk);
        repeat (lfu_pkg::ENTRIES + 10) @(posedge clk);
    endtask

    task automatic write_capacity(int c);
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= lfu_pkg::CAP_BITS'(c);
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        mdl_cap = c;
    endtask

    initial
    begin
        int caps [8];
        int pool;
        caps = '{16, 0, 1, 31, 4, 2, 16, 9};
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_write_data = '0;
        sent_count = 0;
        recv_count = 0;
        mismatch_count = 0;
        cycle_count = 0;
        for (int i = 0; i < lfu_pkg::ENTRIES; i++)
        begin
            mdl_valid[i] = 1'b0;
            mdl_key[i] = '0;
            mdl_data[i] = '0;
            mdl_count[i] = '0;
            mdl_rank[i] = 0;
        end
        mdl_occ = 0;
        mdl_cap = 16;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, get miss on empty, hits, fill past capacity
        pending_txn.push_back(make_txn(lfu_pkg::CMD_GET, '0, '0));
        pending_txn.push_back(make_txn(lfu_pkg::CMD_PUT, '0, 32'h8000_0000));
        pending_txn.push_back(make_txn(lfu_pkg::CMD_PUT, '1, 32'h7fff_ffff));
        pending_txn.push_back(make_txn(lfu_pkg::CMD_GET, '0, '1));
        pending_txn.push_back(make_txn(lfu_pkg::CMD_GET, '1, '0));
        pending_txn.push_back(make_txn(lfu_pkg::CMD_PUT, '1, '1));
        pending_txn.push_back(make_txn(lfu_pkg::CMD_GET, '1, '0));
        for (int i = 0; i < 17; i++)
            pending_txn.push_back(make_txn(lfu_pkg::CMD_PUT,
                                           lfu_pkg::KEY_BITS'(100 + i), $urandom));
        drain();

        // capacity lowered below occupancy: each put miss evicts one entry
        write_capacity(2);
        for (int i = 0; i < 3; i++)
            pending_txn.push_back(make_txn(lfu_pkg::CMD_PUT,
                                           lfu_pkg::KEY_BITS'(5 + i), $urandom));
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_capacity(caps[ph]);
            pool = (ph % 2 == 0) ? 24 : 8;
            for (int i = 0; i < 190; i++)
                pending_txn.push_back(make_txn(logic'($urandom_range(0, 1)),
                                               pick_key(pool), $urandom));
            drain();
        end

        if (mismatch_count == 0 && expected_res.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
rtl/lfu_pkg.sv
rtl/lfu_cell.sv
rtl/lfu_cache_table.sv
verif/lfu_cache_table_tb.sv
